FILE: design/lrd_pkg.sv
// Package for the log record deframer: table sizing, register indexes,
// the phase encoding and the structs passed between modules.
// Depends on nothing; the register file, the parser and the core import it.
`default_nettype none

package lrd_pkg;

  localparam int TYPE_COUNT = 256;
  localparam int TYPE_W     = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
  localparam int HDR_LEN    = 3;
  localparam int CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_TYPE        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_PAYLOAD_LEN = 8'd3;

  localparam logic [7:0] RST_HEADER_FIRST       = 8'd163;
  localparam logic [7:0] RST_HEADER_SECOND      = 8'd149;
  localparam logic [7:0] RST_FORMAT_TYPE        = 8'd128;
  localparam logic [7:0] RST_FORMAT_PAYLOAD_LEN = 8'd86;

  typedef enum logic [1:0] {
    PH_HUNT1   = 2'd0,
    PH_HUNT2   = 2'd1,
    PH_TYPE    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] format_type;
    logic [7:0] format_payload_len;
  } cfg_t;

  // One parser step: the held byte and the table entry read for it.
  typedef struct packed {
    logic       fire;
    logic [7:0] data;
    logic [7:0] tbl_len;
  } step_t;

  typedef struct packed {
    logic              we;
    logic [TYPE_W-1:0] addr;
    logic [7:0]        data;
  } tbl_wr_t;

  function automatic logic type_in_range(input logic [7:0] t);
    return ({1'b0, t} < 9'(TYPE_COUNT));
  endfunction

endpackage

`default_nettype wire

FILE: design/lrd_ifs.sv
// Channel interfaces of the log record deframer: byte input, payload
// output and configuration write channel. No dependencies.
`default_nettype none

interface lrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  modport source (output valid, output data_in, input ready);
  modport sink   (input valid, input data_in, output ready);
endinterface

interface lrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rec_type;
  logic [7:0] byte_pos;
  logic [7:0] data_out;
  logic       is_last;
  logic       is_format;
  modport source (output valid, output rec_type, output byte_pos, output data_out,
                  output is_last, output is_format, input ready);
  modport sink   (input valid, input rec_type, input byte_pos, input data_out,
                  input is_last, input is_format, output ready);
endinterface

interface lrd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/lrd_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module lrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/lrd_cfg_regs.sv
// Configuration register file of the log record deframer.
// Depends on lrd_pkg and lrd_cfg_if.
`default_nettype none

module lrd_cfg_regs import lrd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  lrd_cfg_if.sink    cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.header_first       <= RST_HEADER_FIRST;
      regs.header_second      <= RST_HEADER_SECOND;
      regs.format_type        <= RST_FORMAT_TYPE;
      regs.format_payload_len <= RST_FORMAT_PAYLOAD_LEN;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_HEADER_FIRST:       regs.header_first       <= cfg.data;
        CFG_HEADER_SECOND:      regs.header_second      <= cfg.data;
        CFG_FORMAT_TYPE:        regs.format_type        <= cfg.data;
        CFG_FORMAT_PAYLOAD_LEN: regs.format_payload_len <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/lrd_parser.sv
// Record parser: phase state machine, length-known bits, format learning
// and the result register. Depends on lrd_pkg and lrd_out_if.
`default_nettype none

module lrd_parser import lrd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  regs,
  input  wire step_t step,
  output tbl_wr_t    wr,
  lrd_out_if.source  tx
);

  phase_t            phase, phase_next;
  logic [7:0]        cur_type, cur_type_next;
  logic [7:0]        bytes_left, bytes_left_next;
  logic [7:0]        pay_index, pay_index_next;
  logic [7:0]        learn_type, learn_type_next;
  logic [7:0]        learn_len, learn_len_next;
  logic [TYPE_COUNT-1:0] known;
  logic              b_known;
  logic              fmt;
  logic              last;
  logic              emit;

  assign b_known = type_in_range(step.data) && known[step.data[TYPE_W-1:0]];
  assign fmt     = (cur_type == regs.format_type);
  assign last    = (bytes_left <= 8'd1);

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT1: begin
        if (step.data == regs.header_first) phase_next = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (step.data == regs.header_second)     phase_next = PH_TYPE;
        else if (step.data == regs.header_first) phase_next = PH_HUNT2;
        else                                     phase_next = PH_HUNT1;
      end
      PH_TYPE: begin
        phase_next = PH_HUNT1;
        if (step.data == regs.format_type) begin
          if (regs.format_payload_len != 8'd0) phase_next = PH_PAYLOAD;
        end else if (b_known && (step.tbl_len > 8'(HDR_LEN))) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (last) phase_next = PH_HUNT1;
      end
      default: phase_next = PH_HUNT1;
    endcase
  end

  // Datapath and table write for the current step.
  always_comb begin
    cur_type_next   = cur_type;
    bytes_left_next = bytes_left;
    pay_index_next  = pay_index;
    learn_type_next = learn_type;
    learn_len_next  = learn_len;
    emit            = 1'b0;
    wr.we           = 1'b0;
    case (phase)
      PH_TYPE: begin
        cur_type_next  = step.data;
        pay_index_next = 8'd0;
        if (step.data == regs.format_type) begin
          learn_type_next = 8'd0;
          learn_len_next  = 8'd0;
          if (regs.format_payload_len != 8'd0) bytes_left_next = regs.format_payload_len;
        end else if (b_known && (step.tbl_len > 8'(HDR_LEN))) begin
          bytes_left_next = 8'(step.tbl_len - 8'(HDR_LEN));
        end
      end
      PH_PAYLOAD: begin
        emit = 1'b1;
        if (fmt) begin
          if (pay_index == 8'd0)      learn_type_next = step.data;
          else if (pay_index == 8'd1) learn_len_next  = step.data;
        end
        if (last) begin
          wr.we           = fmt && type_in_range(learn_type_next);
          bytes_left_next = 8'd0;
        end else begin
          bytes_left_next = 8'(bytes_left - 8'd1);
        end
        pay_index_next = 8'(pay_index + 8'd1);
      end
      default: ;
    endcase
    wr.we   = wr.we && step.fire;
    wr.addr = learn_type_next[TYPE_W-1:0];
    wr.data = learn_len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT1;
      cur_type   <= 8'd0;
      bytes_left <= 8'd0;
      pay_index  <= 8'd0;
      learn_type <= 8'd0;
      learn_len  <= 8'd0;
      known      <= '0;
    end else if (step.fire) begin
      phase      <= phase_next;
      cur_type   <= cur_type_next;
      bytes_left <= bytes_left_next;
      pay_index  <= pay_index_next;
      learn_type <= learn_type_next;
      learn_len  <= learn_len_next;
      if (wr.we) known[wr.addr] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (step.fire && emit) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && emit) begin
      tx.rec_type  <= cur_type;
      tx.byte_pos  <= pay_index;
      tx.data_out  <= step.data;
      tx.is_last   <= last;
      tx.is_format <= fmt;
    end
  end

endmodule

`default_nettype wire

FILE: design/log_record_deframer_core.sv
// Log record deframer: one log byte in per cycle while the output is not
// stalled, payload bytes out. Path: a byte passes the input register, then
// the result register; a stalled result holds the input.
// Throughput: one byte per cycle while the output is not stalled, set by the
// one-step phase machine and the single read port of the length table.
// Reset (rst, synchronous): phase to hunting, length-known bits cleared at
// once (no clearing pass), configuration back to its reset values.
`default_nettype none

module log_record_deframer_core import lrd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  lrd_in_if.sink    rx,
  lrd_out_if.source tx,
  lrd_cfg_if.sink   cfg
);

  cfg_t       regs;
  step_t      step;
  tbl_wr_t    wr;
  logic       hold_valid;   // input register holds a byte
  logic [7:0] hold_data;
  logic [7:0] tbl_rdata;
  logic       rx_take;

  lrd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Advance the held byte whenever the result register is free or draining.
  assign step.fire    = hold_valid && (!tx.valid || tx.ready);
  assign step.data    = hold_data;
  assign step.tbl_len = tbl_rdata;

  // Accept a new request when the input register is empty or its held byte moves on in the same cycle.
  assign rx.ready = !hold_valid || step.fire;
  assign rx_take  = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx_take) begin
      hold_valid <= 1'b1;
    end else if (step.fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) hold_data <= rx.data_in;
  end

  // Look up the length with the incoming byte as address so the entry
  // lines up with the held byte. A write lands at the end of a format
  // record, while the two header bytes of the next record still lie ahead of
  // its type byte at the read port, so no bypass is needed. Stale entries after reset are
  // masked by the known bits in the parser.
  lrd_ram #(
    .WIDTH (8),
    .DEPTH (TYPE_COUNT)
  ) u_len_table (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rx_take),
    .raddr (rx.data_in[TYPE_W-1:0]),
    .rdata (tbl_rdata)
  );

  lrd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .step (step),
    .wr   (wr),
    .tx   (tx)
  );

endmodule

`default_nettype wire

FILE: design/lrd_checker.sv
// Port-level checker for log_record_deframer_core, attached by bind.
// Depends on the top level's port names only.
`default_nettype none

module lrd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_ready,
  input wire logic       tx_valid,
  input wire logic       tx_ready,
  input wire logic [7:0] rec_type,
  input wire logic [7:0] byte_pos,
  input wire logic [7:0] data_out,
  input wire logic       is_last,
  input wire logic       is_format
);

  logic [7:0] exp_pos;
  logic [7:0] held_type;
  logic       tx_take;

  assign tx_take = tx_valid && tx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos   <= 8'd0;
      held_type <= 8'd0;
    end else if (tx_take) begin
      exp_pos   <= is_last ? 8'd0 : 8'(byte_pos + 8'd1);
      held_type <= rec_type;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !tx_valid |-> rx_ready)
    else $error("input stalled while result register is empty");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(rec_type) && $stable(byte_pos)
      && $stable(data_out) && $stable(is_last) && $stable(is_format))
    else $error("stalled result changed");

  a_pos_sequence: assert property (@(posedge clk) disable iff (rst)
    tx_take |-> byte_pos == exp_pos)
    else $error("payload position out of sequence");

  a_type_within_record: assert property (@(posedge clk) disable iff (rst)
    tx_take && exp_pos != 8'd0 |-> rec_type == held_type)
    else $error("record type changed inside a payload");

endmodule

bind log_record_deframer_core lrd_checker u_lrd_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx.ready),
  .tx_valid  (tx.valid),
  .tx_ready  (tx.ready),
  .rec_type  (tx.rec_type),
  .byte_pos  (tx.byte_pos),
  .data_out  (tx.data_out),
  .is_last   (tx.is_last),
  .is_format (tx.is_format)
);

`default_nettype wire
